### src/multicycle_mips_subset_core_assert.svh
// ----------------------------------------------------------------------------
// multicycle_mips_subset_core assertion macros
// Concurrent assertion shorthands, clocked on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTICYCLE_MIPS_SUBSET_CORE_ASSERT_SVH
`define MULTICYCLE_MIPS_SUBSET_CORE_ASSERT_SVH

// cons must hold in the cycle after ante
`define MMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// cons must hold in the same cycle as ante
`define MMSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### src/mmsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsc_pkg
// Shared types and constants of the multicycle MIPS subset core.
// ----------------------------------------------------------------------------
package mmsc_pkg;

	localparam int XLEN          = 32;
	localparam int REG_AW        = 5;
	localparam int NUM_REGS      = 32;
	localparam int PHASE_W       = 5;
	localparam int WIDX_W        = 10;
	localparam int MEM_WORDS_DEF = 1024;

	// command codes
	localparam logic [1:0] ACT_WR_MEM = 2'd0;
	localparam logic [1:0] ACT_RUN    = 2'd1;
	localparam logic [1:0] ACT_RD_REG = 2'd2;
	localparam logic [1:0] ACT_RD_MEM = 2'd3;

	typedef struct packed {
		logic [1:0]               action;
		logic [WIDX_W-1:0]        word_index;
		logic [REG_AW-1:0]        reg_select;
		logic signed [XLEN-1:0]   write_data;
	} cmd_t;

	typedef struct packed {
		logic signed [XLEN-1:0]   read_data;
		logic [XLEN-1:0]          pc_value;
		logic [PHASE_W-1:0]       phase;
		logic                     stopped;
	} res_t;

	// control state as it will be after this cycle
	typedef struct packed {
		logic [XLEN-1:0]    pc;
		logic [PHASE_W-1:0] phase;
		logic               halted;
		logic [REG_AW-1:0]  rs;
		logic [REG_AW-1:0]  rt;
		logic [XLEN-1:0]    dmem_addr;
	} look_t;

	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [XLEN-1:0]   data;
	} rf_wr_t;

	typedef struct packed {
		logic            en;
		logic [XLEN-1:0] byte_addr;
		logic [XLEN-1:0] data;
	} mem_wr_t;

endpackage

### src/mmsc_dmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsc_dmem
// Data memory: one write port, one registered read port, write-to-read bypass.
// ----------------------------------------------------------------------------
module mmsc_dmem
	import mmsc_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF,
	localparam int ADDR_W   = $clog2(MEM_WORDS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [XLEN-1:0]   wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [XLEN-1:0]   rdata
);

	logic [XLEN-1:0] mem [MEM_WORDS];
	logic [XLEN-1:0] rd_q;
	logic [XLEN-1:0] fwd_data_q;
	logic            fwd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q       <= mem[raddr];
			fwd_data_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (re) begin
			fwd_q <= we && (waddr == raddr);
		end
	end

	assign rdata = fwd_q ? fwd_data_q : rd_q;

endmodule

### src/mmsc_rf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsc_rf
// General register file: two registered read ports, one write port, bypass,
// per-entry valid bits so unwritten registers read as zero.
// ----------------------------------------------------------------------------
module mmsc_rf
	import mmsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  rf_wr_t            wr,
	input  logic              re,
	input  logic [REG_AW-1:0] raddr_a,
	input  logic [REG_AW-1:0] raddr_b,
	output logic [XLEN-1:0]   rdata_a,
	output logic [XLEN-1:0]   rdata_b
);

	logic [XLEN-1:0]     mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [XLEN-1:0]     rd_a_q, rd_b_q;
	logic [XLEN-1:0]     fwd_data_q;
	logic                va_q, vb_q, fa_q, fb_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (re) begin
			rd_a_q     <= mem[raddr_a];
			rd_b_q     <= mem[raddr_b];
			fwd_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
			fa_q    <= 1'b0;
			fb_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (re) begin
				va_q <= valid_q[raddr_a];
				vb_q <= valid_q[raddr_b];
				fa_q <= wr.en && (wr.addr == raddr_a);
				fb_q <= wr.en && (wr.addr == raddr_b);
			end
		end
	end

	assign rdata_a = fa_q ? fwd_data_q : (va_q ? rd_a_q : '0);
	assign rdata_b = fb_q ? fwd_data_q : (vb_q ? rd_b_q : '0);

endmodule

### src/mmsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsc_ctrl
// Control machine and datapath registers: one clock of the multicycle core
// per step pulse; publishes the post-step state for read-address lookahead.
// ----------------------------------------------------------------------------
module mmsc_ctrl
	import mmsc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [XLEN-1:0] rf_a,
	input  logic [XLEN-1:0] rf_b,
	input  logic [XLEN-1:0] dm_rdata,
	output look_t           nxt,
	output rf_wr_t          rf_wr,
	output mem_wr_t         mem_wr
);

	typedef enum logic [PHASE_W-1:0] {
		S_INIT   = 5'd0,
		S_FETCH  = 5'd1,
		S_DECODE = 5'd2,
		S_ADDR   = 5'd3,
		S_MEMRD  = 5'd4,
		S_LDWB   = 5'd5,
		S_MEMWR  = 5'd6,
		S_REXEC  = 5'd7,
		S_ALUWB  = 5'd8,
		S_BEQ    = 5'd9,
		S_J      = 5'd10,
		S_BNE    = 5'd11,
		S_BLTZ   = 5'd12,
		S_MOVE   = 5'd13,
		S_LUI    = 5'd14,
		S_ORI    = 5'd15,
		S_ANDI   = 5'd16,
		S_SLTI   = 5'd17
	} state_t;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_BLTZ  = 6'h01;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2B;
	localparam logic [5:0] OP_MOVE  = 6'h3F;

	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_SLT = 6'h2A;

	function automatic state_t dispatch(input logic [5:0] op);
		state_t s;
		case (op)
			OP_RTYPE: s = S_REXEC;
			OP_LW:    s = S_ADDR;
			OP_SW:    s = S_ADDR;
			OP_BEQ:   s = S_BEQ;
			OP_J:     s = S_J;
			OP_BNE:   s = S_BNE;
			OP_BLTZ:  s = S_BLTZ;
			OP_MOVE:  s = S_MOVE;
			OP_LUI:   s = S_LUI;
			OP_ORI:   s = S_ORI;
			OP_ANDI:  s = S_ANDI;
			OP_SLTI:  s = S_SLTI;
			default:  s = S_DECODE;
		endcase
		return s;
	endfunction

	state_t            state_q, state_d;
	logic [XLEN-1:0]   pc_q, pc_d;
	logic [XLEN-1:0]   ir_q, ir_d;
	logic [REG_AW-1:0] rs_q, rs_d;
	logic [REG_AW-1:0] rt_q, rt_d;
	logic [XLEN-1:0]   alu_q, alu_d;
	logic [XLEN-1:0]   mdr_q, mdr_d;
	logic              halted_q, halted_d;

	logic [5:0]        op;
	logic [XLEN-1:0]   imm;
	logic              a_lt_b, a_lt_imm;

	assign op       = ir_q[31:26];
	assign imm      = {{16{ir_q[15]}}, ir_q[15:0]};
	assign a_lt_b   = $signed(rf_a) < $signed(rf_b);
	assign a_lt_imm = $signed(rf_a) < $signed(imm);

	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		ir_d     = ir_q;
		rs_d     = rs_q;
		rt_d     = rt_q;
		alu_d    = alu_q;
		mdr_d    = mdr_q;
		halted_d = halted_q;
		rf_wr    = '0;
		mem_wr   = '0;
		if (step && !halted_q) begin
			state_d = S_FETCH;
			case (state_q)
				S_INIT: begin
					state_d = S_FETCH;
				end
				S_FETCH: begin
					ir_d    = dm_rdata;
					pc_d    = pc_q + XLEN'(4);
					state_d = S_DECODE;
				end
				S_DECODE: begin
					if (ir_q == '0) begin
						halted_d = 1'b1;
						state_d  = S_DECODE;
					end else begin
						rs_d    = ir_q[25:21];
						rt_d    = ir_q[20:16];
						alu_d   = pc_q + {imm[XLEN-3:0], 2'b00};
						state_d = dispatch(op);
					end
				end
				S_ADDR: begin
					alu_d   = rf_a + imm;
					state_d = (op == OP_LW) ? S_MEMRD : S_MEMWR;
				end
				S_MEMRD: begin
					mdr_d   = dm_rdata;
					state_d = S_LDWB;
				end
				S_LDWB: begin
					rf_wr.en   = 1'b1;
					rf_wr.addr = ir_q[20:16];
					rf_wr.data = mdr_q;
				end
				S_MEMWR: begin
					mem_wr.en        = 1'b1;
					mem_wr.byte_addr = alu_q;
					mem_wr.data      = rf_b;
				end
				S_REXEC: begin
					case (ir_q[5:0])
						FN_ADD:  alu_d = rf_a + rf_b;
						FN_SUB:  alu_d = rf_a - rf_b;
						FN_AND:  alu_d = rf_a & rf_b;
						FN_OR:   alu_d = rf_a | rf_b;
						FN_SLT:  alu_d = {{(XLEN-1){1'b0}}, a_lt_b};
						default: alu_d = alu_q;
					endcase
					state_d = S_ALUWB;
				end
				S_ALUWB: begin
					rf_wr.en   = 1'b1;
					rf_wr.addr = (op[5:1] == 5'd0) ? ir_q[15:11] : rt_q;
					rf_wr.data = alu_q;
				end
				S_BEQ: begin
					if (rf_a == rf_b) begin
						pc_d = alu_q;
					end
					alu_d = rf_a - rf_b;
				end
				S_BNE: begin
					if (rf_a != rf_b) begin
						pc_d = alu_q;
					end
					alu_d = rf_a - rf_b;
				end
				S_BLTZ: begin
					if (rf_a[XLEN-1]) begin
						pc_d = alu_q;
					end
					alu_d = {{(XLEN-1){1'b0}}, rf_a[XLEN-1]};
				end
				S_J: begin
					pc_d = {4'b0000, ir_q[25:0], 2'b00};
				end
				S_MOVE: begin
					rf_wr.en   = 1'b1;
					rf_wr.addr = rs_q;
					rf_wr.data = rf_b;
				end
				S_LUI: begin
					rf_wr.en   = 1'b1;
					rf_wr.addr = rt_q;
					rf_wr.data = {ir_q[15:0], 16'h0000};
				end
				S_ORI: begin
					alu_d   = rf_a | imm;
					state_d = S_ALUWB;
				end
				S_ANDI: begin
					alu_d   = rf_a & imm;
					state_d = S_ALUWB;
				end
				S_SLTI: begin
					alu_d   = {{(XLEN-1){1'b0}}, a_lt_imm};
					state_d = S_ALUWB;
				end
				default: begin
					state_d = S_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			pc_q     <= '0;
			ir_q     <= '0;
			rs_q     <= '0;
			rt_q     <= '0;
			alu_q    <= '0;
			mdr_q    <= '0;
			halted_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pc_q     <= pc_d;
			ir_q     <= ir_d;
			rs_q     <= rs_d;
			rt_q     <= rt_d;
			alu_q    <= alu_d;
			mdr_q    <= mdr_d;
			halted_q <= halted_d;
		end
	end

	// fetch reads at PC, memory-read phase at the computed address
	assign nxt.pc        = pc_d;
	assign nxt.phase     = state_d;
	assign nxt.halted    = halted_d;
	assign nxt.rs        = rs_d;
	assign nxt.rt        = rt_d;
	assign nxt.dmem_addr = (state_d == S_MEMRD) ? alu_d : pc_d;

endmodule

### src/multicycle_mips_subset_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicycle_mips_subset_core
// Multicycle MIPS subset core driven one command at a time: memory word
// write/read, register read, or one clock of the control machine.
// ----------------------------------------------------------------------------
// Throughput is one command per cycle while the result side takes results; a
// command loads the command register at its transfer, its result loads the
// result register when the command retires, and a stalled result holds the
// command register without losing anything. The
// figure is set by the read ports: the data memory and the register file are
// read at the command transfer edge, with addresses taken from the state as
// it stands after the command ahead retires, and a write by that command to
// the same word is bypassed into the read data. The data memory has no reset
// and no clearing pass (an unwritten word reads as whatever it holds); the
// register file reads zero until a register is first written. MEM_WORDS must
// be a power of two; memory addresses wrap modulo MEM_WORDS.
// ----------------------------------------------------------------------------
module multicycle_mips_subset_core
	import mmsc_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int ADDR_W = $clog2(MEM_WORDS);

	// command register
	logic            valid_s1;
	cmd_t            cmd_s1;

	// result register
	logic            res_valid_q;
	res_t            res_q;

	logic            advance;
	logic            accept;
	logic            step;

	look_t           nxt;
	rf_wr_t          rf_wr;
	mem_wr_t         mem_wr;

	logic [XLEN-1:0]   rf_a, rf_b;
	logic [REG_AW-1:0] rf_raddr_a;

	logic              dm_we;
	logic [ADDR_W-1:0] dm_waddr, dm_raddr;
	logic [XLEN-1:0]   dm_wdata, dm_rdata;
	logic [XLEN-1:0]   rd_value;

	// the command register retires when the result register is free or drains
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign accept    = cmd_valid && cmd_ready;
	assign step      = advance && (cmd_s1.action == ACT_RUN);

	mmsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rf_a     (rf_a),
		.rf_b     (rf_b),
		.dm_rdata (dm_rdata),
		.nxt      (nxt),
		.rf_wr    (rf_wr),
		.mem_wr   (mem_wr)
	);

	// port A serves both register reads and the rs operand
	assign rf_raddr_a = (cmd.action == ACT_RD_REG) ? cmd.reg_select : nxt.rs;

	mmsc_rf u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (rf_wr),
		.re      (accept),
		.raddr_a (rf_raddr_a),
		.raddr_b (nxt.rt),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	// host write or store, never both in one retire
	assign dm_we    = advance && ((cmd_s1.action == ACT_WR_MEM) || mem_wr.en);
	assign dm_waddr = (cmd_s1.action == ACT_WR_MEM) ? ADDR_W'(cmd_s1.word_index)
	                                                : mem_wr.byte_addr[ADDR_W+1:2];
	assign dm_wdata = (cmd_s1.action == ACT_WR_MEM) ? cmd_s1.write_data : mem_wr.data;
	assign dm_raddr = (cmd.action == ACT_RD_MEM) ? ADDR_W'(cmd.word_index)
	                                             : nxt.dmem_addr[ADDR_W+1:2];

	mmsc_dmem #(
		.MEM_WORDS (MEM_WORDS)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (dm_we),
		.waddr  (dm_waddr),
		.wdata  (dm_wdata),
		.re     (accept),
		.raddr  (dm_raddr),
		.rdata  (dm_rdata)
	);

	always_comb begin
		case (cmd_s1.action)
			ACT_RD_REG: rd_value = rf_a;
			ACT_RD_MEM: rd_value = dm_rdata;
			default:    rd_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (advance) begin
			res_q.read_data <= rd_value;
			res_q.pc_value  <= nxt.pc;
			res_q.phase     <= nxt.phase;
			res_q.stopped   <= nxt.halted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`include "multicycle_mips_subset_core_assert.svh"

	// halt is sticky and freezes the program counter
	`MMSC_ASSERT_NEXT(a_halt_sticky, nxt.halted, nxt.halted, "halt flag dropped")
	`MMSC_ASSERT_NEXT(a_halt_pc_frozen, nxt.halted, $stable(nxt.pc), "PC moved while halted")
	// a retiring command touches at most one store
	`MMSC_ASSERT_NOW(a_single_store, rf_wr.en, !dm_we, "register and memory write together")
	`MMSC_ASSERT_NEXT(a_result_posted, advance, res_valid, "retired command left no result")

endmodule

### test/mmsc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsc_tb_pkg
// Opcode and control-state names plus the scoreboard for the multicycle MIPS
// subset core bench: an architectural copy of the core that predicts one
// result per command and checks what the core returns.
// ----------------------------------------------------------------------------
package mmsc_tb_pkg;
	import mmsc_pkg::*;

	// control machine states, numbered as the core reports them
	typedef enum logic [4:0] {
		ST_INIT    = 5'd0,
		ST_FETCH   = 5'd1,
		ST_DECODE  = 5'd2,
		ST_ADDR    = 5'd3,
		ST_MEM_RD  = 5'd4,
		ST_LD_WB   = 5'd5,
		ST_MEM_WR  = 5'd6,
		ST_R_EXEC  = 5'd7,
		ST_ALU_WB  = 5'd8,
		ST_BEQ     = 5'd9,
		ST_J       = 5'd10,
		ST_BNE     = 5'd11,
		ST_BLTZ    = 5'd12,
		ST_MOVE    = 5'd13,
		ST_LUI     = 5'd14,
		ST_ORI     = 5'd15,
		ST_ANDI    = 5'd16,
		ST_SLTI    = 5'd17
	} core_state_e;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_BLTZ  = 6'h01;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2B;
	localparam logic [5:0] OP_MOVE  = 6'h3F;

	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_SLT = 6'h2A;

	class mips_core_scoreboard;
		logic [31:0] pc;
		logic [31:0] ir;
		logic [31:0] alu;
		logic [31:0] mdr;
		logic [4:0]  rs;
		logic [4:0]  rt;
		core_state_e state;
		bit          halted;
		logic [31:0] gpr [NUM_REGS];
		logic [31:0] dmem [MEM_WORDS_DEF];
		bit          written [MEM_WORDS_DEF];
		res_t        expected_results [$];
		int unsigned errors;

		function new();
			pc     = '0;
			ir     = '0;
			alu    = '0;
			mdr    = '0;
			rs     = '0;
			rt     = '0;
			state  = ST_INIT;
			halted = 1'b0;
			errors = 0;
			foreach (gpr[i]) gpr[i] = '0;
			foreach (dmem[i]) begin
				dmem[i]    = '0;
				written[i] = 1'b0;
			end
		endfunction

		function int unsigned word_at(logic [31:0] byte_addr);
			return (byte_addr >> 2) % MEM_WORDS_DEF;
		endfunction

		// one clock of the control machine
		function void advance_machine();
			logic [5:0]  op;
			logic [31:0] imm;
			logic [31:0] a;
			logic [31:0] b;
			core_state_e nxt;
			if (halted)
				return;
			op  = ir[31:26];
			imm = {{16{ir[15]}}, ir[15:0]};
			a   = gpr[rs];
			b   = gpr[rt];
			nxt = ST_FETCH;
			case (state)
				ST_INIT: nxt = ST_FETCH;
				ST_FETCH: begin
					ir  = dmem[word_at(pc)];
					pc  = pc + 32'd4;
					nxt = ST_DECODE;
				end
				ST_DECODE: begin
					if (ir == '0) begin
						halted = 1'b1;
						nxt    = ST_DECODE;
					end else begin
						rs  = ir[25:21];
						rt  = ir[20:16];
						alu = pc + (imm << 2);
						case (op)
							OP_RTYPE:     nxt = ST_R_EXEC;
							OP_LW, OP_SW: nxt = ST_ADDR;
							OP_BEQ:       nxt = ST_BEQ;
							OP_J:         nxt = ST_J;
							OP_BNE:       nxt = ST_BNE;
							OP_BLTZ:      nxt = ST_BLTZ;
							OP_MOVE:      nxt = ST_MOVE;
							OP_LUI:       nxt = ST_LUI;
							OP_ORI:       nxt = ST_ORI;
							OP_ANDI:      nxt = ST_ANDI;
							OP_SLTI:      nxt = ST_SLTI;
							default:      nxt = ST_DECODE;
						endcase
					end
				end
				ST_ADDR: begin
					alu = a + imm;
					nxt = (op == OP_LW) ? ST_MEM_RD : ST_MEM_WR;
				end
				ST_MEM_RD: begin
					mdr = dmem[word_at(alu)];
					nxt = ST_LD_WB;
				end
				ST_LD_WB: gpr[ir[20:16]] = mdr;
				ST_MEM_WR: begin
					dmem[word_at(alu)]    = b;
					written[word_at(alu)] = 1'b1;
				end
				ST_R_EXEC: begin
					case (ir[5:0])
						FN_ADD:  alu = a + b;
						FN_SUB:  alu = a - b;
						FN_AND:  alu = a & b;
						FN_OR:   alu = a | b;
						FN_SLT:  alu = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
						default: ;
					endcase
					nxt = ST_ALU_WB;
				end
				ST_ALU_WB: begin
					if (op[5:1] == '0)
						gpr[ir[15:11]] = alu;
					else
						gpr[rt] = alu;
				end
				ST_BEQ: begin
					if (a == b)
						pc = alu;
					alu = a - b;
				end
				ST_BNE: begin
					if (a != b)
						pc = alu;
					alu = a - b;
				end
				ST_BLTZ: begin
					if (a[31])
						pc = alu;
					alu = {31'd0, a[31]};
				end
				ST_J:    pc = {4'd0, ir[25:0], 2'd0};
				ST_MOVE: gpr[rs] = b;
				ST_LUI:  gpr[rt] = ir << 16;
				ST_ORI: begin
					alu = a | imm;
					nxt = ST_ALU_WB;
				end
				ST_ANDI: begin
					alu = a & imm;
					nxt = ST_ALU_WB;
				end
				ST_SLTI: begin
					alu = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
					nxt = ST_ALU_WB;
				end
				default: nxt = ST_INIT;
			endcase
			state = nxt;
		endfunction

		// accepted command: update the copy, queue what the core must return
		function void apply_command(cmd_t c);
			res_t        r;
			logic [31:0] rd;
			rd = '0;
			case (c.action)
				ACT_WR_MEM: begin
					dmem[c.word_index]    = c.write_data;
					written[c.word_index] = 1'b1;
				end
				ACT_RUN:    advance_machine();
				ACT_RD_REG: rd = gpr[c.reg_select];
				default:    rd = dmem[c.word_index];
			endcase
			r.read_data = rd;
			r.pc_value  = pc;
			r.phase     = state;
			r.stopped   = halted;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: read_data %h pc %h phase %0d stopped %0b",
					$time, got.read_data, got.pc_value, got.phase, got.stopped);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("read_data", want.read_data, got.read_data);
			compare_field("pc_value", want.pc_value, got.pc_value);
			compare_field("phase", 32'(want.phase), 32'(got.phase));
			compare_field("stopped", 32'(want.stopped), 32'(got.stopped));
		endfunction
	endclass

endpackage

### test/multicycle_mips_subset_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicycle_mips_subset_core_tb
// Feeds the core a stream of memory writes, memory and register reads and
// control clocks, with random gaps on both handshakes, and checks every
// result against a scoreboard that runs its own copy of the machine.
// ----------------------------------------------------------------------------
// Programs are built on the fly: whenever the machine sits in fetch, the
// bench may plant a fresh, well-formed instruction at the fetch address, and
// it always does so when that word was never written or would stop the core
// (zero word or unknown opcode). A load about to read a word nobody wrote
// gets that word filled first. The run ends on one of the two dead ends of
// the machine, chosen at random: a halt on a zero word, or an unknown opcode
// that parks the machine in decode.
// ----------------------------------------------------------------------------
module multicycle_mips_subset_core_tb;
	import mmsc_pkg::*;
	import mmsc_tb_pkg::*;

	localparam int RANDOM_ITEMS = 840;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd       = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	mips_core_scoreboard sb;

	bit cmd_calm;   // sender runs without gaps while set
	bit res_calm;   // receiver runs without stalls while set
	bit planted;    // fresh instruction already placed for the pending fetch

	multicycle_mips_subset_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	// Gap lengths: mostly zero or short, now and then long, with calm
	// stretches that flip on and off at random.
	function automatic int unsigned pick_gap(inout bit calm);
		int unsigned r;
		if ($urandom_range(0, 63) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic cmd_t make_cmd(logic [1:0] act, logic [31:0] idx, logic [31:0] sel,
			logic [31:0] data);
		cmd_t c;
		c.action     = act;
		c.word_index = idx[WIDX_W-1:0];
		c.reg_select = sel[REG_AW-1:0];
		c.write_data = data;
		return c;
	endfunction

	function automatic bit op_known(logic [5:0] op);
		case (op)
			OP_RTYPE, OP_BLTZ, OP_J, OP_BEQ, OP_BNE, OP_SLTI, OP_ANDI, OP_ORI,
			OP_LUI, OP_LW, OP_SW, OP_MOVE: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Well-formed instruction with random operands. Branches get equal
	// registers half the time so that both outcomes show up; jumps mostly
	// stay low in the address space.
	function automatic logic [31:0] random_instr();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(0, 15))
			0, 1, 2: begin
				w[31:26] = OP_RTYPE;
				case ($urandom_range(0, 5))
					0: w[5:0] = FN_ADD;
					1: w[5:0] = FN_SUB;
					2: w[5:0] = FN_AND;
					3: w[5:0] = FN_OR;
					4: w[5:0] = FN_SLT;
					default: ;  // random funct: ALU result left as is
				endcase
				if (w == '0)
					w[11] = 1'b1;
			end
			3, 4: w[31:26] = OP_LW;
			5, 6: w[31:26] = OP_SW;
			7: begin
				w[31:26] = OP_BEQ;
				if ($urandom_range(0, 1) == 1)
					w[20:16] = w[25:21];
			end
			8: begin
				w[31:26] = OP_BNE;
				if ($urandom_range(0, 1) == 1)
					w[20:16] = w[25:21];
			end
			9: w[31:26] = OP_BLTZ;
			10: begin
				w[31:26] = OP_J;
				if ($urandom_range(0, 3) != 0)
					w[25:8] = '0;
			end
			11: w[31:26] = OP_MOVE;
			12: w[31:26] = OP_LUI;
			13: w[31:26] = OP_ORI;
			14: w[31:26] = OP_ANDI;
			default: w[31:26] = OP_SLTI;
		endcase
		return w;
	endfunction

	// Next step of the machine, or the memory write that has to precede it.
	function automatic cmd_t clock_item();
		cmd_t        c;
		int unsigned w;
		c = make_cmd(ACT_RUN, $urandom(), $urandom(), $urandom());
		if (sb.state == ST_FETCH) begin
			w = sb.word_at(sb.pc);
			if (!sb.written[w] || sb.dmem[w] == '0 || !op_known(sb.dmem[w][31:26])
					|| (!planted && $urandom_range(0, 2) != 0)) begin
				c.action     = ACT_WR_MEM;
				c.word_index = w[WIDX_W-1:0];
				c.write_data = random_instr();
				planted      = 1'b1;
				return c;
			end
		end else if (sb.state == ST_MEM_RD) begin
			w = sb.word_at(sb.alu);
			if (!sb.written[w]) begin
				c.action     = ACT_WR_MEM;
				c.word_index = w[WIDX_W-1:0];
				return c;
			end
		end
		planted = 1'b0;
		return c;
	endfunction

	// Hold the command until its transfer, hand it to the scoreboard, then
	// maybe drop valid for a while. Always called at a rising edge.
	task automatic send_cmd(input cmd_t c);
		int unsigned gap;
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		sb.apply_command(c);
		gap = pick_gap(cmd_calm);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: check each transfer, stall ready at random.
	initial begin
		int unsigned hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready)
				sb.check_result(res);
			if (hold != 0) begin
				res_ready <= 1'b0;
				hold--;
			end else begin
				res_ready <= 1'b1;
				hold = pick_gap(res_calm);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("multicycle_mips_subset_core: mismatch");
		$finish;
	end

	initial begin
		cmd_t        c;
		int unsigned roll;
		int unsigned w;
		logic [31:0] last_word;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes on writes and reads, every command kind,
		// then one lui with the sign bit of its immediate set.
		send_cmd(make_cmd(ACT_WR_MEM, 0, 0, 32'hFFFF_FFFF));
		send_cmd(make_cmd(ACT_WR_MEM, 1023, 31, 32'h0000_0000));
		send_cmd(make_cmd(ACT_WR_MEM, 10'h155, 5'h15, 32'h8000_0000));
		send_cmd(make_cmd(ACT_WR_MEM, 10'h2AA, 5'h0A, 32'h7FFF_FFFF));
		send_cmd(make_cmd(ACT_RD_MEM, 0, 0, 0));
		send_cmd(make_cmd(ACT_RD_MEM, 1023, 31, 32'hFFFF_FFFF));
		send_cmd(make_cmd(ACT_RD_MEM, 10'h155, 0, 0));
		send_cmd(make_cmd(ACT_RD_MEM, 10'h2AA, 0, 0));
		send_cmd(make_cmd(ACT_RD_REG, 0, 0, 0));
		send_cmd(make_cmd(ACT_RD_REG, 1023, 31, 0));
		send_cmd(make_cmd(ACT_RUN, 0, 0, 0));                           // init -> fetch
		send_cmd(make_cmd(ACT_WR_MEM, 0, 0, {OP_LUI, 5'd0, 5'd31, 16'h8000}));
		send_cmd(make_cmd(ACT_RUN, 0, 0, 0));                           // fetch
		send_cmd(make_cmd(ACT_RUN, 0, 0, 0));                           // decode
		send_cmd(make_cmd(ACT_RUN, 0, 0, 0));                           // lui
		send_cmd(make_cmd(ACT_RD_REG, 0, 31, 0));

		// Random: mostly machine clocks, the rest noise writes and reads.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				c = clock_item();
			end else if (roll < 70) begin
				c = make_cmd(ACT_WR_MEM, $urandom(), $urandom(), $urandom());
				if ($urandom_range(0, 1) == 1)
					c.write_data = random_instr();
			end else if (roll < 85) begin
				c = make_cmd(ACT_RD_REG, $urandom(), $urandom(), $urandom());
			end else begin
				// only words that hold something get read back
				w = $urandom_range(0, MEM_WORDS_DEF - 1);
				if (!sb.written[w])
					w = sb.word_at(sb.pc);
				if (sb.written[w])
					c = make_cmd(ACT_RD_MEM, w, $urandom(), $urandom());
				else
					c = make_cmd(ACT_WR_MEM, w, $urandom(), $urandom());
			end
			send_cmd(c);
		end

		// Dead end: steer to the next fetch, then load a zero word (halt) or
		// an unknown opcode and keep clocking; accesses must still work.
		while (sb.state != ST_FETCH)
			send_cmd(clock_item());
		w = sb.word_at(sb.pc);
		if ($urandom_range(0, 1) == 1) begin
			last_word = '0;
		end else begin
			do last_word = $urandom(); while (op_known(last_word[31:26]));
		end
		send_cmd(make_cmd(ACT_WR_MEM, w, $urandom(), last_word));
		repeat (4) send_cmd(make_cmd(ACT_RUN, $urandom(), $urandom(), $urandom()));
		send_cmd(make_cmd(ACT_RD_REG, $urandom(), $urandom(), $urandom()));
		send_cmd(make_cmd(ACT_RD_MEM, w, $urandom(), $urandom()));
		send_cmd(make_cmd(ACT_RUN, $urandom(), $urandom(), $urandom()));
		cmd_valid <= 1'b0;

		// drain, then give a stray result time to show up
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("multicycle_mips_subset_core: match");
		else
			$display("multicycle_mips_subset_core: mismatch");
		$finish;
	end

endmodule

### multicycle_mips_subset_core.f
+incdir+src
src/mmsc_pkg.sv
src/mmsc_dmem.sv
src/mmsc_rf.sv
src/mmsc_ctrl.sv
src/multicycle_mips_subset_core.sv
test/mmsc_tb_pkg.sv
test/multicycle_mips_subset_core_tb.sv
